// File: rtl/core/ibc_pkg.sv
// Shared types, register indexes and reset values for the IMU bias calibrator.
package ibc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int NUM_AXES  = 6;
    localparam int NUM_ACCEL = 3;
    localparam int AXIS_ACCEL_Z = 2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [NUM_AXES-1:0] axes_t;
    typedef sample_t [NUM_ACCEL-1:0] accel_t;

    typedef enum logic [1:0] {
        PH_SETTLE = 2'd0,
        PH_ACCUM  = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_REF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES  = 2'd2;

    localparam logic [15:0] RST_STILL_THRESHOLD = 16'd300;
    localparam logic [15:0] RST_GRAVITY_REF     = 16'd16384;
    localparam logic [7:0]  RST_SETTLE_SAMPLES  = 8'd100;

endpackage

// File: rtl/core/ibc_still_detect.sv
// Stillness test: every accel axis changed by strictly less than the threshold.
module ibc_still_detect
(
    input  ibc_pkg::accel_t current,
    input  ibc_pkg::accel_t previous,
    input  logic [15:0]     threshold,
    output logic            still
);

    logic [ibc_pkg::NUM_ACCEL-1:0] below;
    logic signed [16:0] diff [ibc_pkg::NUM_ACCEL];
    logic [16:0]        mag  [ibc_pkg::NUM_ACCEL];

    always_comb
    begin
        for (int i = 0; i < ibc_pkg::NUM_ACCEL; i++)
        begin
            diff[i]  = $signed({current[i][15], current[i]})
                     - $signed({previous[i][15], previous[i]});
            mag[i]   = diff[i][16] ? 17'(-diff[i]) : 17'(diff[i]);
            below[i] = mag[i] < {1'b0, threshold};
        end
    end

    assign still = &below;

endmodule

// File: rtl/core/ibc_const_div.sv
// Pipelined signed division of the six axis sums by a constant, truncating toward zero.
module ibc_const_div
#(
    parameter int DIVISOR = 100,
    parameter int SUM_W   = 26
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [ibc_pkg::NUM_AXES-1:0][SUM_W-1:0] sums,
    output logic                                   busy,
    output logic                                   done,
    output ibc_pkg::axes_t                         quot
);

    // The magnitude is multiplied by floor(2^K / DIVISOR); with the magnitude below
    // 2^K the estimate is the true quotient or one short, which a remainder check fixes.
    localparam int CNT_W = $clog2(DIVISOR + 1);
    localparam int RW    = CNT_W + 1;
    localparam int K     = SUM_W;
    localparam int PW    = SUM_W + K + 1;
    localparam logic [K:0]    RECIP  = (K + 1)'((64'd1 << K) / DIVISOR);
    localparam logic [RW-1:0] DIV_RW = RW'(DIVISOR);

    logic v1_reg, v2_reg, v3_reg;

    logic [ibc_pkg::NUM_AXES-1:0]             neg1_reg, neg2_reg, neg3_reg;
    logic [ibc_pkg::NUM_AXES-1:0][SUM_W-1:0]  mag1_reg, mag2_reg;
    logic [ibc_pkg::NUM_AXES-1:0][SUM_W-1:0]  qest2_reg;
    logic [ibc_pkg::NUM_AXES-1:0][15:0]       q3_reg;
    logic [ibc_pkg::NUM_AXES-1:0][RW-1:0]     rem3_reg;

    logic [ibc_pkg::NUM_AXES-1:0][SUM_W-1:0]  mag1_next;
    logic [ibc_pkg::NUM_AXES-1:0][PW-1:0]     prod;
    logic [ibc_pkg::NUM_AXES-1:0][2*RW-1:0]   qd;
    logic [ibc_pkg::NUM_AXES-1:0][15:0]       qf;

    always_comb
    begin
        for (int i = 0; i < ibc_pkg::NUM_AXES; i++)
        begin
            mag1_next[i] = sums[i][SUM_W-1] ? SUM_W'(-sums[i]) : sums[i];
            prod[i]      = PW'(mag1_reg[i]) * PW'(RECIP);
            qd[i]        = (2*RW)'(qest2_reg[i][RW-1:0]) * (2*RW)'(DIV_RW);
            qf[i]        = q3_reg[i] + ((rem3_reg[i] >= DIV_RW) ? 16'd1 : 16'd0);
            quot[i]      = neg3_reg[i] ? 16'(-qf[i]) : qf[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ibc_pkg::NUM_AXES; i++)
        begin
            neg1_reg[i]  <= sums[i][SUM_W-1];
            mag1_reg[i]  <= mag1_next[i];
            neg2_reg[i]  <= neg1_reg[i];
            mag2_reg[i]  <= mag1_reg[i];
            qest2_reg[i] <= prod[i][K +: SUM_W];
            neg3_reg[i]  <= neg2_reg[i];
            q3_reg[i]    <= qest2_reg[i][15:0];
            rem3_reg[i]  <= mag2_reg[i][RW-1:0] - qd[i][RW-1:0];
        end
    end

    assign busy = start | v1_reg | v2_reg | v3_reg;
    assign done = v3_reg;

endmodule

// File: rtl/core/imu_bias_calibrator_unit.sv
// Top level of the IMU bias calibrator: sample stream in, corrected stream out.
//
// Each transfer on the s_axis channel carries one six-axis sample (accel x/y/z, gyro
// x/y/z). Each sample produces exactly one transfer on the m_axis channel: the six
// readings minus the current offsets, wrapped to 16 bits, with the phase the sample was
// taken in on tuser (0 settling, 1 accumulating, 2 running).
// A sample goes into an input register, is processed there and lands in the output
// register, from which its result is offered. One sample per cycle is sustained while
// m_axis_tready is high. The sole exception is the sample that completes the average:
// after it, the six offsets are formed by a reciprocal-multiply divider, and the next
// sample waits in the input register until they are ready.
// When m_axis_tready is low the output register holds its result and the input register
// still takes one more sample; only then does s_axis_tready drop.
// The cfg channel writes the threshold, gravity reference and settle length; it is
// always ready and should only be used while no sample is in flight.
// Reset returns to settling with default registers, zero offsets and empty buffers.
module imu_bias_calibrator_unit
#(
    parameter int AVERAGE_SAMPLES = 100
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
    input  logic [ibc_pkg::NUM_AXES*ibc_pkg::SAMPLE_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // corrected_accel_x/y/z, corrected_gyro_x/y/z, 16 bits each
    output logic [ibc_pkg::NUM_AXES*ibc_pkg::SAMPLE_W-1:0] m_axis_tdata,
    // phase
    output logic [1:0]                         m_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ibc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ibc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DIVISOR = (AVERAGE_SAMPLES < 1) ? 1 : AVERAGE_SAMPLES;
    localparam int CNT_W   = $clog2(DIVISOR + 1);
    // Terms reach 17 signed bits (z minus gravity); the sum of DIVISOR of them grows by CNT_W, plus a spare bit.
    localparam int SUM_W   = 18 + CNT_W;

    // Configuration registers.
    logic [15:0] threshold_reg;
    logic [15:0] gravity_reg;
    logic [7:0]  settle_reg;

    // Handshake and payload stages.
    logic            in_valid_reg;
    ibc_pkg::axes_t  in_data_reg;
    logic            out_valid_reg;
    ibc_pkg::axes_t  out_data_reg;
    ibc_pkg::phase_t out_phase_reg;

    // Calibration state.
    ibc_pkg::phase_t                           mode_reg, mode_next;
    logic                                      have_prev_reg, have_prev_next;
    ibc_pkg::accel_t                           prev_reg, prev_next;
    logic [7:0]                                still_run_reg, still_run_next;
    logic [CNT_W-1:0]                          sample_index_reg, sample_index_next;
    logic [ibc_pkg::NUM_AXES-1:0][SUM_W-1:0]   sums_reg, sums_next;
    ibc_pkg::axes_t                            offsets_reg;
    logic                                      div_start_reg, div_start_next;

    logic                                      advance;
    logic                                      still;
    logic                                      div_busy;
    logic                                      div_done;
    ibc_pkg::axes_t                            div_quot;
    ibc_pkg::axes_t                            corrected;
    logic [ibc_pkg::NUM_AXES-1:0][SUM_W-1:0]   term;
    logic [7:0]                                run_count;
    logic [CNT_W-1:0]                          index_inc;

    // The sample in the input register moves on when the output slot is free or being
    // emptied, and not while the divider is still forming new offsets.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready) && !div_busy;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_phase_reg;

    ibc_still_detect u_still
    (
        .current   (in_data_reg[ibc_pkg::NUM_ACCEL-1:0]),
        .previous  (prev_reg),
        .threshold (threshold_reg),
        .still     (still)
    );

    ibc_const_div
    #(
        .DIVISOR (DIVISOR),
        .SUM_W   (SUM_W)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .sums  (sums_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Corrected readings and the accumulation terms, gravity taken off accel z.
    always_comb
    begin
        for (int i = 0; i < ibc_pkg::NUM_AXES; i++)
        begin
            corrected[i] = in_data_reg[i] - offsets_reg[i];
            term[i]      = {{(SUM_W-16){in_data_reg[i][15]}}, in_data_reg[i]};
            if (i == ibc_pkg::AXIS_ACCEL_Z)
            begin
                term[i] = term[i] - {{(SUM_W-16){gravity_reg[15]}}, gravity_reg};
            end
        end
    end

    // Phase sequencing for the sample being processed.
    always_comb
    begin
        mode_next         = mode_reg;
        have_prev_next    = have_prev_reg;
        prev_next         = prev_reg;
        still_run_next    = still_run_reg;
        sample_index_next = sample_index_reg;
        sums_next         = sums_reg;
        div_start_next    = 1'b0;
        run_count         = still_run_reg;
        index_inc         = sample_index_reg + 1'b1;
        if (advance)
        begin
            unique case (mode_reg)
                ibc_pkg::PH_SETTLE:
                begin
                    // The very first sample only primes the previous reading.
                    if (have_prev_reg)
                    begin
                        run_count = still ? still_run_reg + 8'd1 : 8'd0;
                    end
                    still_run_next = run_count;
                    have_prev_next = 1'b1;
                    prev_next      = in_data_reg[ibc_pkg::NUM_ACCEL-1:0];
                    if (run_count >= settle_reg)
                    begin
                        mode_next         = ibc_pkg::PH_ACCUM;
                        sample_index_next = '0;
                        sums_next         = '0;
                    end
                end
                ibc_pkg::PH_ACCUM:
                begin
                    for (int i = 0; i < ibc_pkg::NUM_AXES; i++)
                    begin
                        sums_next[i] = sums_reg[i] + term[i];
                    end
                    sample_index_next = index_inc;
                    if (index_inc >= CNT_W'(DIVISOR))
                    begin
                        mode_next      = ibc_pkg::PH_RUN;
                        div_start_next = 1'b1;
                    end
                end
                ibc_pkg::PH_RUN:
                begin
                    mode_next = ibc_pkg::PH_RUN;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= ibc_pkg::RST_STILL_THRESHOLD;
            gravity_reg      <= ibc_pkg::RST_GRAVITY_REF;
            settle_reg       <= ibc_pkg::RST_SETTLE_SAMPLES;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= ibc_pkg::PH_SETTLE;
            have_prev_reg    <= 1'b0;
            prev_reg         <= '0;
            still_run_reg    <= '0;
            sample_index_reg <= '0;
            sums_reg         <= '0;
            offsets_reg      <= '0;
            div_start_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ibc_pkg::REG_STILL_THRESHOLD: threshold_reg <= cfg_data;
                    ibc_pkg::REG_GRAVITY_REF:     gravity_reg   <= cfg_data;
                    ibc_pkg::REG_SETTLE_SAMPLES:  settle_reg    <= cfg_data[7:0];
                    default:                      settle_reg    <= settle_reg;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            mode_reg         <= mode_next;
            have_prev_reg    <= have_prev_next;
            prev_reg         <= prev_next;
            still_run_reg    <= still_run_next;
            sample_index_reg <= sample_index_next;
            sums_reg         <= sums_next;
            div_start_reg    <= div_start_next;

            if (div_done)
            begin
                offsets_reg <= div_quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg  <= corrected;
            out_phase_reg <= mode_reg;
        end
    end

    // Once running, the block never leaves that phase until reset.
    a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ibc_pkg::PH_RUN |=> mode_reg == ibc_pkg::PH_RUN)
        else $error("left the running phase");

    // The sample count never reaches the divisor while still accumulating.
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ibc_pkg::PH_ACCUM |-> sample_index_reg < CNT_W'(DIVISOR))
        else $error("accumulation count overran");

    // The divider is started only on the move into the running phase.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> mode_reg == ibc_pkg::PH_RUN && $past(mode_reg) == ibc_pkg::PH_ACCUM)
        else $error("divider started outside the end of accumulation");

    // Offsets change only when the divider delivers.
    a_offsets_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !div_done |=> $stable(offsets_reg))
        else $error("offsets changed without a division result");

endmodule

// File: dv/imu_bias_calibrator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IMU bias calibrator: stimulus, predictor and scoreboard.
module imu_bias_calibrator_unit_tb;

    import ibc_pkg::*;

    // The block is built with its usual averaging length so that the predictor and the
    // hardware divide by the same count.
    localparam int AVG_SAMPLES = 100;
    localparam int TOTAL_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 200000;
    // The idling pattern moves on after this many accepted samples.
    localparam int REGIME_LEN  = 50;
    localparam int SHOWN_ERRORS = 10;

    // One corrected sample as it leaves the block: six axes on tdata, phase on tuser.
    typedef struct packed {
        axes_t  vals;
        phase_t ph;
    } corrected_t;

    // A row of the directed table. Rows marked echo are taken in settling with zero
    // offsets, so the sample must come back unchanged with the settling phase.
    typedef struct {
        axes_t smp;
        bit    echo;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [NUM_AXES*SAMPLE_W-1:0]     s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [NUM_AXES*SAMPLE_W-1:0]     m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [CFG_IDX_W-1:0]             cfg_index = REG_STILL_THRESHOLD;
    logic [CFG_DATA_W-1:0]            cfg_data = '0;

    // Predictor state: a copy of the calibration state and of the three registers,
    // brought to their reset values at time zero.
    phase_t          cal_phase = PH_SETTLE;
    bit              cal_have_prev = 1'b0;
    accel_t          cal_prev_accel = '0;
    logic [7:0]      cal_still_run = '0;
    logic [7:0]      cal_sample_count = '0;
    int              cal_sums [NUM_AXES];
    axes_t           cal_offsets = '0;
    logic [15:0]     cal_threshold = RST_STILL_THRESHOLD;
    logic [15:0]     cal_gravity = RST_GRAVITY_REF;
    logic [7:0]      cal_settle = RST_SETTLE_SAMPLES;

    // Corrected samples still owed by the block, oldest first.
    corrected_t      pending_corrected [$];

    int              samples_sent = 0;
    int              results_seen = 0;
    int              mismatch_count = 0;
    int              reg_writes = 0;
    int              phase_seen [4];
    int              cycle_count = 0;
    int              src_idle_pct = 11;
    int              dst_idle_pct = 72;
    accel_t          prev_sent_accel = '0;
    stim_row_t       directed_rows [13];

    imu_bias_calibrator_unit #(
        .AVERAGE_SAMPLES (AVG_SAMPLES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Works out the corrected sample for one accepted input and advances the
    // calibration state exactly as the block should.
    function automatic corrected_t predict_corrected(input axes_t smp);
        corrected_t res;
        bit         still;
        int         cur;
        int         prv;
        int         dif;
        int         thr_i;
        int         grav_i;
        int         avg;
        begin
            thr_i  = int'(cal_threshold);
            grav_i = int'($signed(cal_gravity));
            for (int i = 0; i < NUM_AXES; i++)
                res.vals[i] = smp[i] - cal_offsets[i];
            res.ph = cal_phase;

            case (cal_phase)
                PH_SETTLE:
                begin
                    // The very first sample only becomes the reference for the next one.
                    if (cal_have_prev)
                    begin
                        still = 1'b1;
                        for (int i = 0; i < NUM_ACCEL; i++)
                        begin
                            cur = int'($signed(smp[i]));
                            prv = int'($signed(cal_prev_accel[i]));
                            dif = cur - prv;
                            if (dif < 0)
                                dif = -dif;
                            if (dif >= thr_i)
                                still = 1'b0;
                        end
                        cal_still_run = still ? cal_still_run + 8'd1 : 8'd0;
                    end
                    cal_have_prev  = 1'b1;
                    cal_prev_accel = smp[NUM_ACCEL-1:0];
                    if (cal_still_run >= cal_settle)
                    begin
                        cal_phase        = PH_ACCUM;
                        cal_sample_count = '0;
                        for (int i = 0; i < NUM_AXES; i++)
                            cal_sums[i] = 0;
                    end
                end
                PH_ACCUM:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        cur = int'($signed(smp[i]));
                        if (i == AXIS_ACCEL_Z)
                            cur = cur - grav_i;
                        cal_sums[i] = cal_sums[i] + cur;
                    end
                    cal_sample_count = cal_sample_count + 8'd1;
                    // The completing sample still leaves with the old offsets.
                    if (int'(cal_sample_count) >= AVG_SAMPLES)
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            avg = cal_sums[i] / AVG_SAMPLES;
                            cal_offsets[i] = avg[15:0];
                        end
                        cal_phase = PH_RUN;
                    end
                end
                default:
                begin
                end
            endcase
            return res;
        end
    endfunction

    function automatic axes_t axes(input sample_t ax, input sample_t ay, input sample_t az,
                                   input sample_t gx, input sample_t gy, input sample_t gz);
        return {gz, gy, gx, az, ay, ax};
    endfunction

    // Full-range random sample, with the extreme codes turning up now and then.
    function automatic axes_t rand_axes();
        axes_t s;
        begin
            for (int i = 0; i < NUM_AXES; i++)
                case ($urandom_range(15))
                    0:       s[i] = 16'h8000;
                    1:       s[i] = 16'h7FFF;
                    2:       s[i] = 16'h0000;
                    3:       s[i] = 16'hFFFF;
                    default: s[i] = 16'($urandom_range(65535));
                endcase
            return s;
        end
    endfunction

    // Moves a reading by step, turning back if it would leave the 16-bit range.
    function automatic sample_t nudge(input sample_t base, input int step);
        int v;
        begin
            v = int'($signed(base));
            v = v + step;
            if (v > 32767 || v < -32768)
                v = v - 2 * step;
            return v[15:0];
        end
    endfunction

    // Next accelerometer reading of a sensor at rest: every axis moves by less than the
    // threshold, often by exactly one less. A moving sample pushes one axis to the
    // threshold itself or somewhere random.
    function automatic accel_t drift_accel(input accel_t from, input int thr, input bit moving);
        accel_t a;
        int     mag;
        int     k;
        begin
            for (int i = 0; i < NUM_ACCEL; i++)
            begin
                mag  = ($urandom_range(15) == 0) ? thr - 1 : $urandom_range(thr - 1);
                a[i] = nudge(from[i], $urandom_range(1) ? mag : -mag);
            end
            if (moving)
            begin
                k = $urandom_range(NUM_ACCEL - 1);
                if ($urandom_range(1))
                    a[k] = nudge(from[k], $urandom_range(1) ? thr : -thr);
                else
                    a[k] = 16'($urandom_range(65535));
            end
            return a;
        end
    endfunction

    // Offers one sample, idling first at the current rate, and records what must come
    // back once the transfer has happened. Entered and left at a falling edge.
    task automatic push_sample(input axes_t smp, input bit echo = 1'b0);
        corrected_t want;
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= smp;
            do
                @(posedge clk);
            while (!s_axis_tready);
            want = predict_corrected(smp);
            if (echo)
                want = '{vals: smp, ph: PH_SETTLE};
            pending_corrected.push_back(want);
            prev_sent_accel = smp[NUM_ACCEL-1:0];
            samples_sent++;
            // Sender busy and receiver slow, then the other way round, then flat out.
            case ((samples_sent / REGIME_LEN) % 3)
                0:
                begin
                    src_idle_pct = 11;
                    dst_idle_pct = 72;
                end
                1:
                begin
                    src_idle_pct = 72;
                    dst_idle_pct = 11;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            @(negedge clk);
        end
    endtask

    // Stops offering samples and waits until every owed result has come, then lets the
    // divider or the pipeline run dry.
    task automatic wait_idle(input int tail);
        begin
            s_axis_tvalid <= 1'b0;
            while (pending_corrected.size() != 0)
                @(negedge clk);
            repeat (tail) @(negedge clk);
        end
    endtask

    // Writes all three registers while the block is idle and mirrors them in the
    // predictor at the transfer.
    task automatic apply_settings(input logic [15:0] thr, input logic [15:0] grav,
                                  input logic [7:0] settle);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        begin
            wait_idle(8);
            for (int r = 0; r < 3; r++)
            begin
                case (r)
                    0:
                    begin
                        idx = REG_STILL_THRESHOLD;
                        val = thr;
                    end
                    1:
                    begin
                        idx = REG_GRAVITY_REF;
                        val = grav;
                    end
                    default:
                    begin
                        idx = REG_SETTLE_SAMPLES;
                        val = {8'h00, settle};
                    end
                endcase
                cfg_index <= idx;
                cfg_data  <= val;
                cfg_valid <= 1'b1;
                do
                    @(posedge clk);
                while (!cfg_ready);
                case (idx)
                    REG_STILL_THRESHOLD: cal_threshold = val;
                    REG_GRAVITY_REF:     cal_gravity = val;
                    REG_SETTLE_SAMPLES:  cal_settle = val[7:0];
                    default:
                    begin
                    end
                endcase
                reg_writes++;
                @(negedge clk);
            end
            cfg_valid <= 1'b0;
        end
    endtask

    // Receiver: decides at each falling edge whether it will take a transfer.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    // Scoreboard: every transfer out is checked field by field against the oldest
    // expectation.
    always @(posedge clk)
    begin : check_corrected
        corrected_t want_now;
        bit         field_bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_corrected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                    $display("[%0t] unexpected result %h phase %0d", $realtime,
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want_now  = pending_corrected.pop_front();
                field_bad = 1'b0;
                for (int f = 0; f < NUM_AXES; f++)
                    if (m_axis_tdata[f*SAMPLE_W +: SAMPLE_W] !== want_now.vals[f])
                        field_bad = 1'b1;
                if (m_axis_tuser !== want_now.ph)
                    field_bad = 1'b1;
                if (field_bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("[%0t] result %0d: expected %h phase %0d, got %h phase %0d",
                                 $realtime, results_seen, want_now.vals, want_now.ph,
                                 m_axis_tdata, m_axis_tuser);
                end
                phase_seen[m_axis_tuser]++;
                results_seen++;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        axes_t smp;
        int    walk_thr;
        int    seg_items;
        int    quota;

        for (int i = 0; i < NUM_AXES; i++)
            cal_sums[i] = 0;
        for (int i = 0; i < 4; i++)
            phase_seen[i] = 0;

        // Directed table, taken with the reset registers (threshold 300, settle 100).
        // The first row is the first sample, which only becomes the reference. The
        // extremes jump by a full or half range (moving) or repeat (still); the small rows sit either
        // side of the threshold, at 299 (still) and at exactly 300 (moving).
        directed_rows[0]  = '{axes(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1};
        directed_rows[1]  = '{axes(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000), 1'b1};
        directed_rows[2]  = '{axes(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b1};
        directed_rows[3]  = '{axes(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1};
        directed_rows[4]  = '{axes(16'd299, 16'h0000, 16'h0000, 16'h1234, 16'hA5A5, 16'h5A5A), 1'b0};
        directed_rows[5]  = '{axes(16'h0000, 16'd299, 16'hFED5, 16'hFFFF, 16'h0001, 16'h8001), 1'b0};
        directed_rows[6]  = '{axes(16'h0000, 16'd299, 16'd1, 16'h7FFE, 16'h0000, 16'hC000), 1'b0};
        directed_rows[7]  = '{axes(16'd1, 16'd300, 16'd2, 16'h0100, 16'h0200, 16'h0300), 1'b0};
        directed_rows[8]  = '{axes(16'd1, 16'd300, 16'd2, 16'h0100, 16'h0200, 16'h0300), 1'b0};
        directed_rows[9]  = '{axes(16'hFED6, 16'd1, 16'd301, 16'hF00F, 16'h0FF0, 16'h3333), 1'b0};
        directed_rows[10] = '{axes(16'd2, 16'd1, 16'd301, 16'hCCCC, 16'h5555, 16'hAAAA), 1'b0};
        directed_rows[11] = '{axes(16'd2, 16'd1, 16'd301, 16'h7FFF, 16'h8000, 16'h0001), 1'b1};
        directed_rows[12] = '{axes(16'd2, 16'd1, 16'd301, 16'hFFFF, 16'h0000, 16'h7FFF), 1'b1};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < $size(directed_rows); k++)
            push_sample(directed_rows[k].smp, directed_rows[k].echo);

        // A zero threshold never sees a still sample, however short the settle length.
        apply_settings(16'h0000, 16'($urandom_range(65535)), 8'd1);
        for (int n = 0; n < 120; n++)
            push_sample(rand_axes());

        // A sensor at rest with the odd knock: long still runs that keep being broken,
        // so the run counter climbs high and is cleared again.
        walk_thr = $urandom_range(4000, 100);
        apply_settings(16'(walk_thr), 16'($urandom_range(65535)), 8'($urandom_range(255, 200)));
        for (int n = 0; n < 250; n++)
        begin
            smp = rand_axes();
            smp[NUM_ACCEL-1:0] = drift_accel(prev_sent_accel, walk_thr, $urandom_range(99) < 8);
            push_sample(smp);
        end

        // The widest threshold lets almost any change through, so the longest settle
        // length is reached, and the gravity extreme goes into the sums. Early on a pair
        // of samples jumps by the full range, which is exactly the threshold and so moving.
        apply_settings(16'hFFFF, 16'h8000, 8'd255);
        seg_items = 0;
        while (cal_phase != PH_RUN && seg_items < 3000)
        begin
            smp = rand_axes();
            // Past the early part the accel axes avoid the most negative code, so no
            // full-range jump can break the still run and settling completes.
            if (seg_items >= 80)
                for (int i = 0; i < NUM_ACCEL; i++)
                    if (smp[i] == 16'h8000)
                        smp[i] = 16'h8001;
            if (seg_items < 80 && $urandom_range(19) == 0)
            begin
                smp[0] = 16'h7FFF;
                push_sample(smp);
                smp = rand_axes();
                smp[0] = 16'h8000;
                seg_items++;
            end
            push_sample(smp);
            seg_items++;
        end

        // Running: register writes must leave the offsets and the phase alone.
        quota = (TOTAL_ITEMS - samples_sent) / 3;
        if (quota < 40)
            quota = 40;
        for (int rs = 0; rs < 3; rs++)
        begin
            case (rs)
                0:       apply_settings(16'h0000, 16'h7FFF, 8'd1);
                1:       apply_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                        8'($urandom_range(255, 1)));
                default: apply_settings(16'hFFFF, 16'h8000, 8'd255);
            endcase
            for (int n = 0; n < quota; n++)
                push_sample(rand_axes());
        end

        wait_idle(16);
        $display("%0d samples in, %0d results out in %0d cycles, %0d register writes",
                 samples_sent, results_seen, cycle_count, reg_writes);
        $display("phases seen: settling %0d, accumulating %0d, running %0d; %0d mismatches",
                 phase_seen[PH_SETTLE], phase_seen[PH_ACCUM], phase_seen[PH_RUN],
                 mismatch_count);
        if (mismatch_count == 0 && pending_corrected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
